[hdl/hcbm_pkg.sv]
// ----------------------------------------------------------------------------
// hcbm_pkg
// Shared types and constants of the home computer memory bank mapper.
// ----------------------------------------------------------------------------
package hcbm_pkg;

   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_LOAD  = 2'd2;

   localparam logic [15:0] BANK_ADDR  = 16'h0001;
   localparam logic [7:0]  BANK_RESET = 8'h37;

   localparam int RAM_DEPTH = 65536;
   localparam int IO_DEPTH  = 4096;
   localparam int ROM_DEPTH = 8192;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [2:0] {
      TARGET_RAM   = 3'd0,
      TARGET_IO    = 3'd1,
      TARGET_ROM   = 3'd2,
      TARGET_VIDEO = 3'd3,
      TARGET_SOUND = 3'd4,
      TARGET_TIMER = 3'd5
   } target_code_type;

   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_RAM,
      MEM_IO,
      MEM_ROM
   } mem_sel_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_RESP
   } back_state_type;

   typedef struct packed {
      mem_sel_type     mem_sel;
      logic            mem_write;
      target_code_type target;
      logic            dev;
      logic            dev_write;
      logic [15:0]     address;
      logic [7:0]      data;
   } op_type;

endpackage

[hdl/home_computer_memory_bank_mapper.sv]
// ----------------------------------------------------------------------------
// home_computer_memory_bank_mapper
// Decodes processor bus accesses against the bank byte and serves them
// from main RAM, the I/O store, kernal ROM or an external chip.
//
//   channel | ports                         | handshake
//   --------+-------------------------------+-------------------------
//   request | req_type/address/write_data   | req_valid / req_stall
//   result  | rsp_read_data ... device_data | rsp_valid / rsp_stall
//
// one beat per cycle sustained while rsp_stall is low; a result passes
// through the decode queue and then the registered read port of each
// RAM on its way to the result port.
// after reset the block clears main RAM and the I/O store, one entry a
// cycle, and holds req_stall high meanwhile.
// a decode queue of QUEUE_DEPTH entries lets requests enter while a
// result beat is stalled.
// ----------------------------------------------------------------------------
module home_computer_memory_bank_mapper import hcbm_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [2:0]  rsp_target,
   output logic        rsp_device_access,
   output logic        rsp_device_write,
   output logic [15:0] rsp_device_address,
   output logic [7:0]  rsp_device_data
);

   op_type front_op;
   op_type head_op;
   logic   q_full;
   logic   q_not_empty;
   logic   pop;
   logic   clear_busy;
   logic   push;

   assign req_stall = q_full || clear_busy;
   assign push      = req_valid && !req_stall;

   hcbm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .accept         (!req_stall),
      .req_type       (req_type),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .op             (front_op)
   );

   hcbm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (front_op),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_op   (head_op)
   );

   hcbm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_op               (head_op),
      .pop                (pop),
      .clear_busy         (clear_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_target         (rsp_target),
      .rsp_device_access  (rsp_device_access),
      .rsp_device_write   (rsp_device_write),
      .rsp_device_address (rsp_device_address),
      .rsp_device_data    (rsp_device_data)
   );

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !clear_busy)
      else $error("result beat during clearing pass");

   a_device_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_device_access) |->
         (rsp_target == TARGET_VIDEO || rsp_target == TARGET_SOUND
          || rsp_target == TARGET_TIMER))
      else $error("forwarded access with non-chip target");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_not_empty && !clear_busy))
      else $error("queue popped while empty or clearing");

endmodule

[hdl/hcbm_ram.sv]
// ----------------------------------------------------------------------------
// hcbm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_en) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/hcbm_front.sv]
// ----------------------------------------------------------------------------
// hcbm_front
// Accepts bus accesses, keeps the bank byte and decodes each access into
// a memory operation for the back end.
// ----------------------------------------------------------------------------
module hcbm_front import hcbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        accept,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output op_type      op
);

   logic [7:0] bank_ff;
   logic [7:0] bank_in;
   logic       io_visible;
   logic       rom_visible;
   logic       in_io_range;
   logic       in_rom_range;
   target_code_type io_target;

   assign io_visible   = bank_ff[2] && (bank_ff[2:0] != 3'b100);
   assign rom_visible  = bank_ff[1];
   assign in_io_range  = (req_address[15:12] == 4'hD);
   assign in_rom_range = (req_address[15:13] == 3'b111);

   always_comb begin
      case (req_address[11:8]) inside
         [4'h0:4'h3]: io_target = TARGET_VIDEO;
         [4'h4:4'h7]: io_target = TARGET_SOUND;
         4'hE:        io_target = TARGET_SOUND;
         4'hC, 4'hD:  io_target = TARGET_TIMER;
         default:     io_target = TARGET_IO;
      endcase
   end

   always_comb begin
      op.mem_sel   = MEM_NONE;
      op.mem_write = 1'b0;
      op.target    = TARGET_RAM;
      op.dev       = 1'b0;
      op.dev_write = 1'b0;
      op.address   = req_address;
      op.data      = req_write_data;
      case (req_type)
         REQ_LOAD: begin
            op.mem_sel   = MEM_ROM;
            op.mem_write = 1'b1;
            op.target    = TARGET_ROM;
         end
         REQ_READ, REQ_WRITE: begin
            op.mem_write = (req_type == REQ_WRITE);
            if (in_io_range && io_visible) begin
               op.target = io_target;
               if (io_target == TARGET_IO) begin
                  op.mem_sel = MEM_IO;
               end else begin
                  op.dev       = 1'b1;
                  op.dev_write = op.mem_write;
                  if (io_target == TARGET_TIMER && op.mem_write) begin
                     op.mem_sel = MEM_RAM;
                  end
               end
            end else if (in_rom_range && !op.mem_write && rom_visible) begin
               op.mem_sel = MEM_ROM;
               op.target  = TARGET_ROM;
            end else begin
               op.mem_sel = MEM_RAM;
            end
         end
         default: begin
            op.mem_sel = MEM_NONE;
         end
      endcase
   end

   always_comb begin
      bank_in = bank_ff;
      if (req_valid && accept && op.mem_sel == MEM_RAM && op.mem_write
          && req_address == BANK_ADDR) begin
         bank_in = req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= BANK_RESET;
      end else begin
         bank_ff <= bank_in;
      end
   end

endmodule

[hdl/hcbm_queue.sv]
// ----------------------------------------------------------------------------
// hcbm_queue
// Short first-in first-out queue of decoded operations.
// ----------------------------------------------------------------------------
module hcbm_queue import hcbm_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output logic   full,
   output logic   not_empty,
   output op_type head_op
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[hdl/hcbm_back.sv]
// ----------------------------------------------------------------------------
// hcbm_back
// Carries out decoded operations on main RAM, I/O store and kernal ROM,
// clears main RAM and the I/O store after reset and holds the result beat.
// ----------------------------------------------------------------------------
module hcbm_back import hcbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  op_type      q_op,
   output logic        pop,
   output logic        clear_busy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [2:0]  rsp_target,
   output logic        rsp_device_access,
   output logic        rsp_device_write,
   output logic [15:0] rsp_device_address,
   output logic [7:0]  rsp_device_data
);

   localparam int RAM_AW = $clog2(RAM_DEPTH);
   localparam int IO_AW  = $clog2(IO_DEPTH);
   localparam int ROM_AW = $clog2(ROM_DEPTH);

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [RAM_AW-1:0] clr_ff;
   logic [RAM_AW-1:0] clr_in;
   op_type            op_ff;

   logic              ram_en, ram_we;
   logic [RAM_AW-1:0] ram_addr;
   logic [7:0]        ram_wdata, ram_rdata;
   logic              io_en, io_we;
   logic [IO_AW-1:0]  io_addr;
   logic [7:0]        io_wdata, io_rdata;
   logic              rom_en, rom_we;
   logic [7:0]        rom_rdata;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pop       = 1'b0;
      ram_en    = 1'b0;
      ram_we    = q_op.mem_write;
      ram_addr  = q_op.address[RAM_AW-1:0];
      ram_wdata = q_op.data;
      io_en     = 1'b0;
      io_we     = q_op.mem_write;
      io_addr   = q_op.address[IO_AW-1:0];
      io_wdata  = q_op.data;
      case (state_ff)
         BACK_CLEAR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = (clr_ff == BANK_ADDR[RAM_AW-1:0]) ? BANK_RESET : 8'h00;
            io_en     = (clr_ff[RAM_AW-1:IO_AW] == '0);
            io_we     = 1'b1;
            io_addr   = clr_ff[IO_AW-1:0];
            io_wdata  = 8'h00;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            if (q_not_empty) begin
               pop      = 1'b1;
               state_in = BACK_RESP;
            end
         end
         BACK_RESP: begin
            if (!rsp_stall) begin
               if (q_not_empty) begin
                  pop = 1'b1;
               end else begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      if (pop) begin
         ram_en = (q_op.mem_sel == MEM_RAM);
         io_en  = (q_op.mem_sel == MEM_IO);
      end
   end

   assign rom_en = pop && (q_op.mem_sel == MEM_ROM);
   assign rom_we = q_op.mem_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= q_op;
      end
   end

   hcbm_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_main_ram (
      .clock   (clock),
      .en      (ram_en),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   hcbm_ram #(.WIDTH(8), .DEPTH(IO_DEPTH)) u_io_store (
      .clock   (clock),
      .en      (io_en),
      .wr_en   (io_we),
      .addr    (io_addr),
      .wr_data (io_wdata),
      .rd_data (io_rdata)
   );

   hcbm_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_kernal_rom (
      .clock   (clock),
      .en      (rom_en),
      .wr_en   (rom_we),
      .addr    (q_op.address[ROM_AW-1:0]),
      .wr_data (q_op.data),
      .rd_data (rom_rdata)
   );

   always_comb begin
      rsp_read_data = 8'h00;
      if (!op_ff.mem_write) begin
         case (op_ff.mem_sel)
            MEM_RAM: rsp_read_data = ram_rdata;
            MEM_IO:  rsp_read_data = io_rdata;
            MEM_ROM: rsp_read_data = rom_rdata;
            default: rsp_read_data = 8'h00;
         endcase
      end
   end

   assign clear_busy         = (state_ff == BACK_CLEAR);
   assign rsp_valid          = (state_ff == BACK_RESP);
   assign rsp_target         = op_ff.target;
   assign rsp_device_access  = op_ff.dev;
   assign rsp_device_write   = op_ff.dev_write;
   assign rsp_device_address = op_ff.dev ? op_ff.address : 16'h0000;
   assign rsp_device_data    = op_ff.dev_write ? op_ff.data : 8'h00;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the memory bank mapper. A directed table covers reset values,
// every chip window, the bank bits and the ignored request code. A long
// random run follows. Both sides idle and stall at random. Every result
// beat is checked in order against typed table values, or else against a
// behavioral copy of the banking decode, main RAM, I/O store and kernal ROM.
// ----------------------------------------------------------------------------
module tb_top import hcbm_pkg::*; ();

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_BEATS = 1100;
   localparam int STEADY_FIRST = 500;
   localparam int STEADY_LAST  = 800;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [7:0]      read_data;
      target_code_type target;
      logic            device_access;
      logic            device_write;
      logic [15:0]     device_address;
      logic [7:0]      device_data;
   } bus_result_type;

   typedef struct {
      logic [1:0]     kind;
      logic [15:0]    addr;
      logic [7:0]     data;
      bit             typed;
      bus_result_type res;
   } bus_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_READ;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [2:0]  rsp_target;
   logic        rsp_device_access;
   logic        rsp_device_write;
   logic [15:0] rsp_device_address;
   logic [7:0]  rsp_device_data;

   // behavioral copy of the mapper state
   logic [7:0]  ram_image [RAM_DEPTH];
   logic [7:0]  io_image [IO_DEPTH];
   logic [7:0]  rom_image [ROM_DEPTH];
   bit          rom_loaded [ROM_DEPTH];
   logic [7:0]  bank_image;

   bus_result_type pending_results [$];
   bus_case_type   directed_cases [$];
   int             mismatches = 0;
   bit             steady = 1'b0;

   always #4 clock = ~clock;

   home_computer_memory_bank_mapper DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_address        (req_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_target         (rsp_target),
      .rsp_device_access  (rsp_device_access),
      .rsp_device_write   (rsp_device_write),
      .rsp_device_address (rsp_device_address),
      .rsp_device_data    (rsp_device_data)
   );

   function automatic void store_ram(input logic [15:0] a, input logic [7:0] d);
      ram_image[a] = d;
      if (a == BANK_ADDR) begin
         bank_image = d;
      end
   endfunction

   function automatic bus_result_type decode_access(input logic [1:0] kind,
                                                    input logic [15:0] a,
                                                    input logic [7:0] d);
      bus_result_type res;
      logic [2:0]     low_bank;
      bit             io_on;
      bit             is_write;
      res = '0;
      low_bank = bank_image[2:0];
      io_on = low_bank[2] && (low_bank != 3'b100);
      is_write = (kind == REQ_WRITE);
      if (kind == REQ_LOAD) begin
         rom_image[a[12:0]] = d;
         rom_loaded[a[12:0]] = 1'b1;
         res.target = TARGET_ROM;
      end else if (kind == REQ_READ || kind == REQ_WRITE) begin
         if (a >= 16'hD000 && a < 16'hE000 && io_on) begin
            if (a < 16'hD400) begin
               res.target = TARGET_VIDEO;
            end else if (a < 16'hD800) begin
               res.target = TARGET_SOUND;
            end else if (a >= 16'hDE00 && a < 16'hDF00) begin
               res.target = TARGET_SOUND;
            end else if (a >= 16'hDC00 && a < 16'hDE00) begin
               res.target = TARGET_TIMER;
            end else begin
               res.target = TARGET_IO;
            end
            if (res.target == TARGET_IO) begin
               if (is_write) begin
                  io_image[a[11:0]] = d;
               end else begin
                  res.read_data = io_image[a[11:0]];
               end
            end else begin
               res.device_access = 1'b1;
               res.device_address = a;
               if (is_write) begin
                  res.device_write = 1'b1;
                  res.device_data = d;
                  // timer writes fall through to RAM as well
                  if (res.target == TARGET_TIMER) begin
                     store_ram(a, d);
                  end
               end
            end
         end else if (a >= 16'hE000 && !is_write && bank_image[1]) begin
            res.target = TARGET_ROM;
            res.read_data = rom_image[a[12:0]];
         end else begin
            res.target = TARGET_RAM;
            if (is_write) begin
               store_ram(a, d);
            end else begin
               res.read_data = ram_image[a];
            end
         end
      end
      return res;
   endfunction

   task automatic add_case(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [7:0] data, input bit typed,
                           input logic [7:0] rd, input target_code_type tgt,
                           input bit dev, input bit dw,
                           input logic [15:0] da, input logic [7:0] dd);
      bus_case_type c;
      c.kind = kind;
      c.addr = addr;
      c.data = data;
      c.typed = typed;
      c.res = '{rd, tgt, dev, dw, da, dd};
      directed_cases.push_back(c);
   endtask

   task automatic send_access(input logic [1:0] kind, input logic [15:0] addr,
                              input logic [7:0] data, input bit typed,
                              input bus_result_type typed_res);
      bus_result_type res;
      res = decode_access(kind, addr, data);
      pending_results.push_back(typed ? typed_res : res);
      while (!steady && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_address <= addr;
      req_write_data <= data;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   initial begin
      bus_result_type none;
      logic [1:0]     kind;
      logic [15:0]    addr;
      logic [7:0]     data;
      int             pick;
      int             useful;
      none = '0;
      foreach (ram_image[i]) ram_image[i] = 8'h00;
      foreach (io_image[i]) io_image[i] = 8'h00;
      ram_image[BANK_ADDR] = BANK_RESET;
      bank_image = BANK_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_case(REQ_READ,   16'h0001, 8'h00, 1, 8'h37, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'h0000, 8'hFF, 1, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_LOAD,   16'hFFFF, 8'hFF, 1, 8'h00, TARGET_ROM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'hFFFF, 8'h00, 1, 8'hFF, TARGET_ROM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_LOAD,   16'h0000, 8'hA5, 1, 8'h00, TARGET_ROM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'h0000, 8'h00, 0, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'hE000, 8'h00, 1, 8'hA5, TARGET_ROM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_WRITE,  16'hD000, 8'h5A, 1, 8'h00, TARGET_VIDEO, 1, 1, 16'hD000, 8'h5A);
      add_case(REQ_READ,   16'hD3FF, 8'hFF, 1, 8'h00, TARGET_VIDEO, 1, 0, 16'hD3FF, 8'h00);
      add_case(REQ_WRITE,  16'hD400, 8'hFF, 1, 8'h00, TARGET_SOUND, 1, 1, 16'hD400, 8'hFF);
      add_case(REQ_READ,   16'hDEFF, 8'h00, 1, 8'h00, TARGET_SOUND, 1, 0, 16'hDEFF, 8'h00);
      add_case(REQ_WRITE,  16'hDC00, 8'h81, 1, 8'h00, TARGET_TIMER, 1, 1, 16'hDC00, 8'h81);
      add_case(REQ_READ,   16'hDDFF, 8'h00, 1, 8'h00, TARGET_TIMER, 1, 0, 16'hDDFF, 8'h00);
      add_case(REQ_WRITE,  16'hD800, 8'h3C, 1, 8'h00, TARGET_IO,    0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'hD800, 8'h00, 0, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'hDF00, 8'h00, 1, 8'h00, TARGET_IO,    0, 0, 16'h0000, 8'h00);
      add_case(REQ_WRITE,  16'hDBFF, 8'h77, 0, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_UNUSED, 16'hFFFF, 8'hFF, 1, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      // bank 0x34: I/O and ROM hidden
      add_case(REQ_WRITE,  BANK_ADDR, 8'h34, 0, 8'h00, TARGET_RAM,  0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'hDC00, 8'h00, 0, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'hD000, 8'h00, 0, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_WRITE,  16'hFFFF, 8'h99, 0, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'hFFFF, 8'h00, 0, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      // bank 0xF3: ROM visible, I/O hidden
      add_case(REQ_WRITE,  BANK_ADDR, 8'hF3, 0, 8'h00, TARGET_RAM,  0, 0, 16'h0000, 8'h00);
      add_case(REQ_READ,   16'hFFFF, 8'h00, 0, 8'h00, TARGET_RAM,   0, 0, 16'h0000, 8'h00);
      add_case(REQ_WRITE,  BANK_ADDR, BANK_RESET, 0, 8'h00, TARGET_RAM, 0, 0, 16'h0000, 8'h00);

      foreach (directed_cases[i]) begin
         send_access(directed_cases[i].kind, directed_cases[i].addr,
                     directed_cases[i].data, directed_cases[i].typed,
                     directed_cases[i].res);
      end

      useful = 0;
      while (useful < RANDOM_BEATS) begin
         steady <= (useful >= STEADY_FIRST && useful < STEADY_LAST);
         pick = $urandom_range(99);
         data = 8'($urandom_range(255));
         addr = 16'($urandom_range(65535));
         if (pick < 8) begin
            kind = REQ_WRITE;
            addr = BANK_ADDR;
         end else if (pick < 10) begin
            kind = REQ_UNUSED;
         end else begin
            if (pick < 18) begin
               kind = REQ_LOAD;
            end else begin
               kind = $urandom_range(1) ? REQ_WRITE : REQ_READ;
            end
            // narrow offsets so reads find earlier writes
            if ($urandom_range(1)) begin
               addr[7:0] = 8'($urandom_range(15));
            end
            case ($urandom_range(3))
               0: addr[15:8] = 8'($urandom_range(3));
               1: addr[15:12] = 4'hD;
               2: addr[15:13] = 3'b111;
               default: ;
            endcase
         end
         // never read a kernal byte that was not loaded; load it instead
         if (kind == REQ_READ && addr >= 16'hE000 && bank_image[1] &&
             !rom_loaded[addr[12:0]]) begin
            kind = REQ_LOAD;
         end
         if (kind != REQ_UNUSED) begin
            useful++;
         end
         send_access(kind, addr, data, 1'b0, none);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 30);
   end

   always @(negedge clock) begin : take_result
      bus_result_type want;
      bus_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_read_data, rsp_target, rsp_device_access, rsp_device_write,
                rsp_device_address, rsp_device_data};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: result beat with no access pending", $time);
            end
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: mismatch exp rd=%h tgt=%0d dev=%b dw=%b da=%h dd=%h",
                           $time, want.read_data, want.target, want.device_access,
                           want.device_write, want.device_address, want.device_data);
                  $display("%0t:          got rd=%h tgt=%0d dev=%b dw=%b da=%h dd=%h",
                           $time, rsp_read_data, rsp_target, rsp_device_access,
                           rsp_device_write, rsp_device_address, rsp_device_data);
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
hdl/hcbm_pkg.sv
hdl/hcbm_ram.sv
hdl/hcbm_front.sv
hdl/hcbm_queue.sv
hdl/hcbm_back.sv
hdl/home_computer_memory_bank_mapper.sv
tb/tb_top.sv
